// ===== rtl/laft_pkg.sv =====
// shared constants and register indexes for the looping animation frame timer
`default_nettype none
package laft_pkg;

    localparam int TIME_WIDTH = 16;

    // accumulator holds leftover time plus one elapsed value
    localparam int ACC_W = TIME_WIDTH + 1;
    // frame index plus frame steps, one spare bit for the carry
    localparam int POS_W = ((ACC_W > 16) ? ACC_W : 16) + 1;
    localparam int CNT_W = $clog2(POS_W + 1);

    // low TIME_WIDTH bits of a 16-bit time field
    localparam logic [15:0] TIME_MASK16 =
        (TIME_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << TIME_WIDTH) - 32'd1);
    // the accumulator can only exceed 32 bits at the widest time setting
    localparam bit TIME_SAT = (TIME_WIDTH >= 32);

    localparam logic [2:0] REG_FRAME_PERIOD = 3'd0;
    localparam logic [2:0] REG_FRAME_COUNT  = 3'd1;
    localparam logic [2:0] REG_LOOP_ENABLE  = 3'd2;
    localparam logic [2:0] REG_LOOP_LIMIT   = 3'd3;
    localparam logic [2:0] REG_START_FRAME  = 3'd4;

    localparam logic REQ_ADVANCE = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    typedef struct packed {
        logic         finished;
        logic         visible;
        logic         running;
        logic [15:0]  current_frame;
    } laft_result_t;

endpackage
`default_nettype wire

// ===== rtl/looping_animation_frame_timer_unit.sv =====
// looping animation frame timer: control, state and result register
//
//  channel   direction  handshake               payload
//  s_*       in         s_tvalid / s_tready     s_tdata, s_tuser (request kind)
//  m_*       out        m_tvalid / m_tready     m_tdata (one result per request)
//  cfg_*     in         cfg_we                  cfg_addr, cfg_wdata
//
// a restart or a disabled advance goes straight to ST_WRITE, which loads the result register
// once the output register is empty or being read
// an advance runs two serial divisions in one shared divider, in ST_DIV1 and then ST_DIV2,
// and ST_WRITE then loads the result register once the output register is empty or being read
// reset clears the state to frame 0, an endless loop budget, running
// s_tready is low while a request is in work; the next request may be taken
// while a result still waits in the output register
`default_nettype none
module looping_animation_frame_timer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // elapsed_time[15:0], main_frame[47:16], first_frame[63:48]
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // current_frame[15:0], running[16], visible[17], finished[18]
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata
);
    import laft_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV1  = 2'd1;
    localparam logic [1:0] ST_DIV2  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0]            st_reg, st_next;
    logic [15:0]           period_reg, period_next;
    logic [15:0]           count_reg, count_next;
    logic                  loop_en_reg, loop_en_next;
    logic [15:0]           limit_reg, limit_next;
    logic [31:0]           start_frame_reg, start_frame_next;
    logic [TIME_WIDTH-1:0] time_left_reg, time_left_next;
    logic [TIME_WIDTH-1:0] time_rem_reg, time_rem_next;
    logic [15:0]           frame_idx_reg, frame_idx_next;
    logic [15:0]           loops_left_reg, loops_left_next;
    logic                  run_reg, run_next;
    logic                  cmp_reg, cmp_next;
    logic                  fin_reg, fin_next;
    logic                  out_valid_reg, out_valid_next;
    laft_result_t          out_reg, out_next;

    logic [15:0]           elapsed_time;
    logic [31:0]           main_frame;
    logic [15:0]           first_frame;
    logic [15:0]           period_eff;
    logic [TIME_WIDTH-1:0] elapsed_eff;
    logic [ACC_W-1:0]      sum;
    logic [ACC_W-1:0]      acc;
    logic                  accept;
    logic                  enabled;
    logic                  stop;

    logic                  div_start;
    logic [POS_W-1:0]      div_dividend;
    logic [15:0]           div_divisor;
    logic                  div_done;
    logic [POS_W-1:0]      div_quo;
    logic [15:0]           div_rem;

    laft_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign elapsed_time = s_tdata[15:0];
    assign main_frame   = s_tdata[47:16];
    assign first_frame  = s_tdata[63:48];

    assign s_tready = (st_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign enabled  = (period_eff != 16'd0) && (count_reg != 16'd0);

    assign period_eff  = period_reg & TIME_MASK16;
    assign elapsed_eff = TIME_WIDTH'(elapsed_time & TIME_MASK16);
    assign sum         = {1'b0, time_left_reg} + {1'b0, elapsed_eff};
    // saturate at TIME_WIDTH bits of ones
    assign acc = (TIME_SAT && sum[ACC_W-1]) ? {1'b0, {TIME_WIDTH{1'b1}}} : sum;

    assign div_start = (accept && (s_tuser == REQ_ADVANCE) && enabled)
                     || ((st_reg == ST_DIV1) && div_done);
    assign div_dividend = (st_reg == ST_IDLE) ? POS_W'(acc)
                        : POS_W'(frame_idx_reg) + div_quo;
    assign div_divisor  = (st_reg == ST_IDLE) ? period_eff : count_reg;

    // div_quo holds the pass count during the second division's done cycle
    assign stop = (div_quo != '0)
               && (!loop_en_reg
                   || ((loops_left_reg != 16'd0) && (div_quo >= POS_W'(loops_left_reg))));

    always_comb
    begin
        st_next          = st_reg;
        period_next      = period_reg;
        count_next       = count_reg;
        loop_en_next     = loop_en_reg;
        limit_next       = limit_reg;
        start_frame_next = start_frame_reg;
        time_left_next   = time_left_reg;
        time_rem_next    = time_rem_reg;
        frame_idx_next   = frame_idx_reg;
        loops_left_next  = loops_left_reg;
        run_next         = run_reg;
        cmp_next         = cmp_reg;
        fin_next         = fin_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;

        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_addr)
                REG_FRAME_PERIOD:
                begin
                    period_next    = cfg_wdata[15:0];
                    time_left_next = '0;
                end
                REG_FRAME_COUNT:  count_next       = cfg_wdata[15:0];
                REG_LOOP_ENABLE:  loop_en_next     = cfg_wdata[0];
                REG_LOOP_LIMIT:   limit_next       = cfg_wdata[15:0];
                REG_START_FRAME:  start_frame_next = cfg_wdata;
                default: ;
            endcase
        end

        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmp_next = (main_frame >= start_frame_reg);
                    fin_next = 1'b0;
                    if (s_tuser == REQ_RESTART)
                    begin
                        run_next        = 1'b1;
                        time_left_next  = '0;
                        frame_idx_next  = first_frame;
                        loops_left_next = limit_reg;
                        st_next         = ST_WRITE;
                    end
                    else if (enabled)
                    begin
                        st_next = ST_DIV1;
                    end
                    else
                    begin
                        st_next = ST_WRITE;
                    end
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    time_rem_next = TIME_WIDTH'(div_rem);
                    st_next       = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    if (stop)
                    begin
                        fin_next        = run_reg;
                        time_left_next  = '0;
                        frame_idx_next  = 16'd0;
                        loops_left_next = 16'd1;
                        run_next        = 1'b0;
                    end
                    else
                    begin
                        // with no pass spent the remainder equals the position
                        frame_idx_next = div_rem;
                        time_left_next = time_rem_reg;
                        if ((div_quo != '0) && (loops_left_reg != 16'd0))
                        begin
                            loops_left_next = loops_left_reg - div_quo[15:0];
                        end
                    end
                    st_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next         = 1'b1;
                    out_next.current_frame = frame_idx_reg;
                    out_next.running       = run_reg;
                    out_next.visible       = run_reg && cmp_reg;
                    out_next.finished      = fin_reg;
                    st_next                = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= ST_IDLE;
            period_reg      <= 16'd0;
            count_reg       <= 16'd0;
            loop_en_reg     <= 1'b0;
            limit_reg       <= 16'd0;
            start_frame_reg <= 32'd0;
            time_left_reg   <= '0;
            frame_idx_reg   <= 16'd0;
            loops_left_reg  <= 16'd0;
            run_reg         <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            st_reg          <= st_next;
            period_reg      <= period_next;
            count_reg       <= count_next;
            loop_en_reg     <= loop_en_next;
            limit_reg       <= limit_next;
            start_frame_reg <= start_frame_next;
            time_left_reg   <= time_left_next;
            frame_idx_reg   <= frame_idx_next;
            loops_left_reg  <= loops_left_next;
            run_reg         <= run_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_rem_reg <= time_rem_next;
        cmp_reg      <= cmp_next;
        fin_reg      <= fin_next;
        out_reg      <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg};

endmodule
`default_nettype wire

// ===== rtl/laft_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module laft_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [laft_pkg::POS_W-1:0] dividend,
    input  wire logic [15:0]              divisor,
    output logic                          done,
    output logic [laft_pkg::POS_W-1:0]    quotient,
    output logic [15:0]                   remainder
);
    import laft_pkg::*;

    logic [POS_W-1:0] q_reg, q_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [16:0]      r_sh;
    logic [16:0]      r_sub;
    logic             ge;

    always_comb
    begin
        r_sh  = {rem_reg, q_reg[POS_W-1]};
        ge    = (r_sh >= {1'b0, d_reg});
        r_sub = r_sh - {1'b0, d_reg};

        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            q_next    = dividend;
            rem_next  = 16'd0;
            d_next    = divisor;
            cnt_next  = CNT_W'(POS_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[POS_W-2:0], ge};
            rem_next = ge ? r_sub[15:0] : r_sh[15:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ===== verif/tb_looping_animation_frame_timer_unit.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the looping animation frame timer unit
module tb_looping_animation_frame_timer_unit;
    import laft_pkg::*;

    localparam int STALL_PCT      = 15;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int SHOWN_ERRORS   = 10;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;   // elapsed_time[15:0], main_frame[47:16], first_frame[63:48]
    logic        s_tuser   = 1'b0; // req_type
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // current_frame[15:0], running[16], visible[17], finished[18]
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [31:0] cfg_wdata = '0;

    // register shadow
    logic [15:0] cfg_period     = '0;
    logic [15:0] cfg_count      = '0;
    logic        cfg_loop_en    = 1'b0;
    logic [15:0] cfg_loop_limit = '0;
    logic [31:0] cfg_start      = '0;

    // animation state as the block should hold it
    logic [31:0] anim_time_left = '0;
    logic [15:0] anim_frame     = '0;
    logic [15:0] anim_loops     = '0;
    logic        anim_run       = 1'b1;

    laft_result_t frame_results_due[$];

    bit calm = 1'b0;
    int mismatch_count = 0;
    int requests_sent  = 0;
    int random_sent    = 0;
    int restarts_sent  = 0;
    int results_seen   = 0;
    int stops_seen     = 0;
    int reg_writes     = 0;
    int quiet_cycles   = 0;

    looping_animation_frame_timer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // steps the animation state by one request and returns the result it should report
    function automatic laft_result_t predict_frame_step(logic req, logic [15:0] elapsed,
                                                        logic [31:0] main_frame,
                                                        logic [15:0] first);
        logic [63:0]  period;
        logic [63:0]  acc;
        logic [63:0]  steps;
        logic [63:0]  pos;
        logic [63:0]  passes;
        logic         ended;
        laft_result_t res;
        ended = 1'b0;
        if (req == REQ_RESTART)
        begin
            anim_run       = 1'b1;
            anim_time_left = '0;
            anim_frame     = first;
            anim_loops     = cfg_loop_limit;
        end
        else
        begin
            period = 64'(cfg_period & TIME_MASK16);
            if (period != 0 && cfg_count != 0)
            begin
                acc = 64'(anim_time_left) + 64'(elapsed & TIME_MASK16);
                if (acc > 64'hFFFF_FFFF)
                    acc = 64'hFFFF_FFFF;
                steps  = 64'(32'(acc / period));
                pos    = 64'(anim_frame) + steps;
                passes = pos / 64'(cfg_count);
                if (passes != 0 && (!cfg_loop_en ||
                                    (anim_loops != 0 && passes >= 64'(anim_loops))))
                begin
                    ended          = anim_run;
                    anim_time_left = '0;
                    anim_frame     = '0;
                    anim_loops     = 16'd1;
                    anim_run       = 1'b0;
                end
                else
                begin
                    if (passes != 0)
                    begin
                        pos = pos % 64'(cfg_count);
                        // endless looping leaves the budget alone
                        if (anim_loops != 0)
                            anim_loops = anim_loops - 16'(passes);
                    end
                    anim_frame     = pos[15:0];
                    anim_time_left = 32'(acc - period * steps);
                end
            end
        end
        res.current_frame = anim_frame;
        res.running       = anim_run;
        res.visible       = anim_run && (main_frame >= cfg_start);
        res.finished      = ended;
        return res;
    endfunction

    task automatic flag_error(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        laft_result_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (frame_results_due.size() == 0)
                flag_error("unexpected result", 32'd0, 32'(m_tdata));
            else
            begin
                due = frame_results_due.pop_front();
                if (due.finished)
                    stops_seen++;
                if (m_tdata[15:0] != due.current_frame)
                    flag_error("current_frame", 32'(due.current_frame), 32'(m_tdata[15:0]));
                if (m_tdata[16] != due.running)
                    flag_error("running", 32'(due.running), 32'(m_tdata[16]));
                if (m_tdata[17] != due.visible)
                    flag_error("visible", 32'(due.visible), 32'(m_tdata[17]));
                if (m_tdata[18] != due.finished)
                    flag_error("finished", 32'(due.finished), 32'(m_tdata[18]));
            end
        end
    end

    // result side back-pressure
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(99) >= STALL_PCT);

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles, %0d results still due",
                     WATCHDOG_LIMIT, frame_results_due.size());
            $display("tb_looping_animation_frame_timer_unit: FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic req, input logic [15:0] elapsed,
                                input logic [31:0] main_frame, input logic [15:0] first);
        if (!calm && $urandom_range(99) < STALL_PCT)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {first, main_frame, elapsed};
        s_tuser  <= req;
        do
            @(posedge clk);
        while (!s_tready);
        frame_results_due.push_back(predict_frame_step(req, elapsed, main_frame, first));
        requests_sent++;
        if (req == REQ_RESTART)
            restarts_sent++;
    endtask

    // first_frame is random on an advance, it must not matter
    task automatic advance_by(input logic [15:0] elapsed, input logic [31:0] main_frame);
        send_request(REQ_ADVANCE, elapsed, main_frame, 16'($urandom));
    endtask

    // elapsed_time is random on a restart, it must not matter
    task automatic restart_at(input logic [15:0] first, input logic [31:0] main_frame);
        send_request(REQ_RESTART, 16'($urandom), main_frame, first);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        reg_writes++;
        case (idx)
            REG_FRAME_PERIOD:
            begin
                cfg_period     = value[15:0];
                anim_time_left = '0;
            end
            REG_FRAME_COUNT:  cfg_count      = value[15:0];
            REG_LOOP_ENABLE:  cfg_loop_en    = value[0];
            REG_LOOP_LIMIT:   cfg_loop_limit = value[15:0];
            REG_START_FRAME:  cfg_start      = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic test_after_reset();
        // all registers zero, so advancing is disabled
        advance_by(16'hFFFF, 32'h0000_0000);
        restart_at(16'h0005, 32'hFFFF_FFFF);
        advance_by(16'h0000, 32'h0000_0000);
    endtask

    task automatic test_stop_without_loops();
        drain_results();
        write_reg(REG_FRAME_PERIOD, 32'd3);
        write_reg(REG_FRAME_COUNT, 32'd4);
        write_reg(REG_LOOP_ENABLE, 32'd0);
        write_reg(REG_LOOP_LIMIT, 32'd0);
        write_reg(REG_START_FRAME, 32'hFFFF_FFFF);
        restart_at(16'd0, 32'hFFFF_FFFF);
        advance_by(16'd5, 32'hFFFF_FFFE);
        advance_by(16'd7, 32'hFFFF_FFFF);
        // already stopped: clears again, no second finish
        advance_by(16'd20, 32'hFFFF_FFFF);
        advance_by(16'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_finite_loops();
        drain_results();
        write_reg(REG_LOOP_ENABLE, 32'd1);
        write_reg(REG_LOOP_LIMIT, 32'd2);
        restart_at(16'd1, 32'hFFFF_FFFF);
        advance_by(16'd12, 32'hFFFF_FFFF);
        advance_by(16'd12, 32'hFFFF_FFFF);
        // two passes in one request use the whole budget
        restart_at(16'd0, 32'hFFFF_FFFF);
        advance_by(16'd24, 32'hFFFF_FFFF);
    endtask

    task automatic test_endless_and_extremes();
        drain_results();
        write_reg(REG_FRAME_PERIOD, 32'd1);
        write_reg(REG_FRAME_COUNT, 32'd7);
        write_reg(REG_LOOP_LIMIT, 32'd0);
        write_reg(REG_START_FRAME, 32'd0);
        restart_at(16'd0, 32'd0);
        advance_by(16'hFFFF, 32'hFFFF_FFFF);
        drain_results();
        write_reg(REG_FRAME_PERIOD, 32'hFFFF);
        write_reg(REG_FRAME_COUNT, 32'hFFFF);
        advance_by(16'hFFFF, 32'd0);
        advance_by(16'hFFFE, 32'd1);
        advance_by(16'h0001, 32'd2);
    endtask

    task automatic test_index_beyond_pass();
        drain_results();
        write_reg(REG_FRAME_PERIOD, 32'd10);
        write_reg(REG_FRAME_COUNT, 32'd100);
        write_reg(REG_LOOP_LIMIT, 32'd3);
        write_reg(REG_START_FRAME, 32'd1000);
        restart_at(16'd50, 32'd999);
        drain_results();
        // shrinking the pass leaves the index five passes deep
        write_reg(REG_FRAME_COUNT, 32'd10);
        advance_by(16'd0, 32'd1000);
        drain_results();
        write_reg(REG_LOOP_LIMIT, 32'hFFFF);
        restart_at(16'hFFFF, 32'd1001);
        advance_by(16'd0, 32'd1000);
        advance_by(16'd9, 32'd1000);
        drain_results();
        // a period write drops the leftover time
        write_reg(REG_FRAME_PERIOD, 32'd10);
        advance_by(16'd1, 32'd1000);
    endtask

    task automatic test_register_writes();
        drain_results();
        write_reg(3'd5, 32'hFFFF_FFFF);
        write_reg(3'd6, 32'h0000_0001);
        write_reg(3'd7, 32'hA5A5_5A5A);
        // bits above each register's width are dropped
        write_reg(REG_FRAME_COUNT, 32'hFFFF_0000);
        write_reg(REG_LOOP_ENABLE, 32'hFFFF_FFFE);
        advance_by(16'hFFFF, 32'd1000);
        drain_results();
        write_reg(REG_FRAME_COUNT, 32'hFFFF_0003);
        write_reg(REG_FRAME_PERIOD, 32'h8000_0002);
        advance_by(16'd7, 32'd999);
    endtask

    task automatic test_random_phases();
        int          phase;
        int          n_items;
        int          span;
        int          pick;
        logic [15:0] elapsed;
        logic [15:0] first;
        logic [31:0] main_frame;
        logic [15:0] value;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            drain_results();
            calm = (phase == 2);

            pick = $urandom_range(19);
            if (pick == 0)      value = 16'd0;
            else if (pick == 1) value = 16'hFFFF;
            else if (pick < 4)  value = 16'd1;
            else if (pick < 13) value = 16'($urandom_range(2, 64));
            else                value = 16'($urandom);
            write_reg(REG_FRAME_PERIOD, {16'($urandom), value});

            pick = $urandom_range(19);
            if (pick == 0)      value = 16'd0;
            else if (pick == 1) value = 16'hFFFF;
            else if (pick < 4)  value = 16'd1;
            else if (pick < 14) value = 16'($urandom_range(2, 12));
            else                value = 16'($urandom);
            write_reg(REG_FRAME_COUNT, {16'($urandom), value});

            write_reg(REG_LOOP_ENABLE, {31'($urandom), 1'($urandom_range(3) != 0)});

            pick = $urandom_range(19);
            if (pick < 4)       value = 16'd0;
            else if (pick == 4) value = 16'hFFFF;
            else if (pick < 13) value = 16'($urandom_range(1, 4));
            else                value = 16'($urandom);
            write_reg(REG_LOOP_LIMIT, {16'($urandom), value});

            pick = $urandom_range(9);
            if (pick == 0)      write_reg(REG_START_FRAME, 32'd0);
            else if (pick == 1) write_reg(REG_START_FRAME, 32'hFFFF_FFFF);
            else                write_reg(REG_START_FRAME, $urandom);

            if ($urandom_range(3) == 0)
                write_reg(3'($urandom_range(5, 7)), $urandom);

            span = (cfg_period == 0) ? 100 : 3 * int'(cfg_period) + 1;
            if (span > 65535)
                span = 65535;
            n_items = $urandom_range(40, 160);
            for (int i = 0; i < n_items && random_sent < RANDOM_ITEMS; i++)
            begin
                pick = $urandom_range(9);
                if (pick < 5)       main_frame = cfg_start + 32'($urandom_range(0, 6)) - 32'd3;
                else if (pick < 8)  main_frame = $urandom;
                else if (pick == 8) main_frame = 32'd0;
                else                main_frame = 32'hFFFF_FFFF;

                if ((i == 0 && $urandom_range(1) == 0) || $urandom_range(99) < 6)
                begin
                    if (cfg_count != 0 && $urandom_range(4) != 0)
                        first = 16'($urandom_range(0, int'(cfg_count) - 1));
                    else
                        first = 16'($urandom);
                    restart_at(first, main_frame);
                end
                else
                begin
                    pick = $urandom_range(9);
                    if (pick == 0)      elapsed = 16'd0;
                    else if (pick == 1) elapsed = 16'hFFFF;
                    else if (pick == 2) elapsed = 16'($urandom);
                    else                elapsed = 16'($urandom_range(0, span));
                    advance_by(elapsed, main_frame);
                end
                random_sent++;
            end
            phase++;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_stop_without_loops();
        test_finite_loops();
        test_endless_and_extremes();
        test_index_beyond_pass();
        test_register_writes();
        test_random_phases();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d requests (%0d restarts) and %0d register writes driven",
                 requests_sent, restarts_sent, reg_writes);
        $display("%0d results checked, %0d animation stops, %0d mismatches",
                 results_seen, stops_seen, mismatch_count);
        if (mismatch_count == 0 && frame_results_due.size() == 0)
            $display("tb_looping_animation_frame_timer_unit: PASS");
        else
            $display("tb_looping_animation_frame_timer_unit: FAIL");
        $finish;
    end

endmodule

// ===== looping_animation_frame_timer_unit.f =====
rtl/laft_pkg.sv
rtl/laft_div.sv
rtl/looping_animation_frame_timer_unit.sv
verif/tb_looping_animation_frame_timer_unit.sv
